// ===== rtl/mbap_frame_deframer_top_macros.svh =====
// ----------------------------------------------------------------------------
// mbap frame deframer assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef MBAP_FRAME_DEFRAMER_TOP_MACROS_SVH
`define MBAP_FRAME_DEFRAMER_TOP_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define MBFD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define MBFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mbfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbfd_pkg
// types and constants shared by the mbap frame deframer modules
// ----------------------------------------------------------------------------
package mbfd_pkg;

    localparam logic [8:0]  LEN_CLAMP     = 9'd256;
    localparam logic [8:0]  HDR_BYTES     = 9'd6;
    localparam logic [8:0]  MIN_FRAME     = 9'd8;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [8:0]  POS_LEN_HIGH  = 9'd4;
    localparam logic [8:0]  POS_LEN_LOW   = 9'd5;
    localparam logic [8:0]  POS_MAX       = 9'd261;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       frame_abort;
        logic       frame_last;
        logic [8:0] byte_position;
        logic [7:0] out_byte;
    } result_t;

    typedef struct packed {
        logic                   full;
        logic                   not_empty;
        logic [QUEUE_CNT_W-1:0] count;
    } queue_status_t;

endpackage

// ===== rtl/mbfd_front.sv =====
// ----------------------------------------------------------------------------
// mbfd_front
// accepts bytes and ticks, tracks frame position, length and idle time
// ----------------------------------------------------------------------------
module mbfd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  in_valid,
    input  logic                  in_kind,
    input  logic [7:0]            in_byte,
    output logic                  in_ready,
    input  mbfd_pkg::queue_status_t q_status,
    output logic                  push,
    output mbfd_pkg::result_t     push_data
);

    logic [15:0] idle_timeout_reg;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [8:0]  frame_total_reg, frame_total_next;
    logic [15:0] idle_count_reg, idle_count_next;

    logic        accept;
    logic [15:0] len_word;
    logic [8:0]  len_clamped;
    logic [8:0]  len_total;
    logic [8:0]  total_eff;
    logic [9:0]  pos_plus1;
    logic        last;
    logic [15:0] idle_inc;
    logic        abort;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        len_word    = {length_high_reg, in_byte};
        len_clamped = (len_word > {7'd0, mbfd_pkg::LEN_CLAMP}) ? mbfd_pkg::LEN_CLAMP
                                                               : len_word[8:0];
        len_total   = len_clamped + mbfd_pkg::HDR_BYTES;
        if (len_total < mbfd_pkg::MIN_FRAME) begin
            len_total = mbfd_pkg::MIN_FRAME;
        end
        total_eff = (byte_count_reg == mbfd_pkg::POS_LEN_LOW) ? len_total : frame_total_reg;
        pos_plus1 = {1'b0, byte_count_reg} + 10'd1;
        last      = (pos_plus1 >= {1'b0, total_eff});
        // idle counter saturates so a maximal timeout never fires
        idle_inc  = (idle_count_reg == mbfd_pkg::IDLE_MAX) ? idle_count_reg
                                                          : idle_count_reg + 16'd1;
        abort     = (byte_count_reg != 9'd0) && (idle_inc > idle_timeout_reg);
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        length_high_next = length_high_reg;
        frame_total_next = frame_total_reg;
        idle_count_next  = idle_count_reg;
        push             = 1'b0;
        push_data        = '0;
        if (accept) begin
            if (in_kind == mbfd_pkg::KIND_DATA) begin
                idle_count_next         = 16'd0;
                push                    = 1'b1;
                push_data.out_byte      = in_byte;
                push_data.byte_position = byte_count_reg;
                push_data.frame_last    = last;
                push_data.frame_abort   = 1'b0;
                if (byte_count_reg == mbfd_pkg::POS_LEN_HIGH) begin
                    length_high_next = in_byte;
                end
                if (byte_count_reg == mbfd_pkg::POS_LEN_LOW) begin
                    frame_total_next = len_total;
                end
                if (last) begin
                    byte_count_next  = 9'd0;
                    length_high_next = 8'd0;
                    frame_total_next = mbfd_pkg::MIN_FRAME;
                end else begin
                    byte_count_next = pos_plus1[8:0];
                end
            end else begin
                idle_count_next = idle_inc;
                if (abort) begin
                    push                    = 1'b1;
                    push_data.out_byte      = 8'd0;
                    push_data.byte_position = byte_count_reg;
                    push_data.frame_last    = 1'b0;
                    push_data.frame_abort   = 1'b1;
                    byte_count_next         = 9'd0;
                    length_high_next        = 8'd0;
                    frame_total_next        = mbfd_pkg::MIN_FRAME;
                    idle_count_next         = 16'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= mbfd_pkg::TIMEOUT_RESET;
            byte_count_reg   <= 9'd0;
            length_high_reg  <= 8'd0;
            frame_total_reg  <= mbfd_pkg::MIN_FRAME;
            idle_count_reg   <= 16'd0;
        end else begin
            if (cfg_wr_en) begin
                idle_timeout_reg <= cfg_wr_data;
            end
            byte_count_reg  <= byte_count_next;
            length_high_reg <= length_high_next;
            frame_total_reg <= frame_total_next;
            idle_count_reg  <= idle_count_next;
        end
    end

endmodule

// ===== rtl/mbfd_queue.sv =====
// ----------------------------------------------------------------------------
// mbfd_queue
// short result queue between the classifying front and the output stage
// ----------------------------------------------------------------------------
module mbfd_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  mbfd_pkg::result_t       push_data,
    input  logic                    pop,
    output mbfd_pkg::result_t       pop_data,
    output mbfd_pkg::queue_status_t status
);

    mbfd_pkg::result_t                  entry_reg [mbfd_pkg::QUEUE_DEPTH];
    logic [mbfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mbfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mbfd_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    localparam logic [mbfd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        mbfd_pkg::QUEUE_PTR_W'(mbfd_pkg::QUEUE_DEPTH - 1);
    localparam logic [mbfd_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        mbfd_pkg::QUEUE_CNT_W'(mbfd_pkg::QUEUE_DEPTH);

    assign status.full      = (count_reg == CNT_FULL);
    assign status.not_empty = (count_reg != '0);
    assign status.count     = count_reg;
    assign pop_data         = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/mbfd_back.sv =====
// ----------------------------------------------------------------------------
// mbfd_back
// output register stage that drains the queue onto the result stream
// ----------------------------------------------------------------------------
module mbfd_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mbfd_pkg::queue_status_t q_status,
    input  mbfd_pkg::result_t       q_data,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,
    output logic                    m_tlast,
    output logic [0:0]              m_tuser
);

    logic              valid_reg, valid_next;
    mbfd_pkg::result_t out_reg;

    // refill whenever the output slot is empty or being taken
    assign pop = q_status.not_empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= q_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, out_reg.byte_position, out_reg.out_byte};
    assign m_tlast  = out_reg.frame_last;
    assign m_tuser  = out_reg.frame_abort;

endmodule

// ===== rtl/mbap_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// mbap_frame_deframer_top
// splits a modbus tcp byte stream into mbap frames
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one byte (s_tuser = 0) or one time tick (s_tuser = 1).
//   m_ channel carries each byte with its offset in the frame; m_tlast marks
//   the closing byte of a frame, m_tuser marks a partial frame dropped after
//   idle_timeout ticks with no byte (offset field then gives bytes dropped).
//   cfg_wr_en / cfg_wr_data load idle_timeout; write only while idle.
// timing:
//   one transaction per cycle is accepted while s_tready is high; every step
//   is a few compares in the front stage. a result is written into the
//   two-entry queue, then into the output register, where it can be taken.
//   ticks that cause no result leave the output side untouched.
// reset:
//   aresetn low clears frame position, idle count and queue; idle_timeout
//   returns to 500 and the frame length to eight bytes.
// stall:
//   with m_tready low the queue fills; s_tready drops once both queue
//   entries are held and rises right after the edge at which m_ hands over
//   a transaction.
// ----------------------------------------------------------------------------
`include "mbap_frame_deframer_top_macros.svh"

module mbap_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // idle_timeout
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // rx_byte
    input  logic [0:0]  s_tuser,        // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // out_byte [7:0], byte_position [16:8], zero fill
    output logic        m_tlast,        // frame_last
    output logic [0:0]  m_tuser         // frame_abort
);

    mbfd_pkg::queue_status_t q_status;
    mbfd_pkg::result_t       q_push_data;
    mbfd_pkg::result_t       q_pop_data;
    logic                    q_push;
    logic                    q_pop;

    mbfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_kind     (s_tuser[0]),
        .in_byte     (s_tdata),
        .in_ready    (s_tready),
        .q_status    (q_status),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    mbfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    mbfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_data   (q_pop_data),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `MBFD_ASSERT_SAME(a_no_overflow, aclk, aresetn, q_push, !q_status.full, "result pushed into full queue")
    `MBFD_ASSERT_SAME(a_abort_form, aclk, aresetn, m_tvalid && m_tuser[0], (m_tdata[7:0] == 8'd0) && !m_tlast, "abort result carries data")
    `MBFD_ASSERT_SAME(a_pos_range, aclk, aresetn, m_tvalid, m_tdata[16:8] <= mbfd_pkg::POS_MAX, "byte position out of range")
    `MBFD_ASSERT_NEXT(a_drain, aclk, aresetn, q_status.not_empty && (!m_tvalid || m_tready), m_tvalid, "queued result not moved to output")

endmodule
